/* rtl/rqr_pkg.sv */
// Shared constants, types and index helpers for the ready queue with remove.
// Used by ready_queue_with_remove and its testbench; depends on nothing else.
package rqr_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int PID_W = 32;
    localparam int OP_W  = 2;
    localparam int ST_W  = 2;
    localparam int OCC_W = 5;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [PID_W-1:0] t_pid;
    typedef logic [OP_W-1:0]  t_op;
    typedef logic [ST_W-1:0]  t_status;

    localparam t_op OP_PUSH     = 2'd0;
    localparam t_op OP_POP      = 2'd1;
    localparam t_op OP_CONTAINS = 2'd2;
    localparam t_op OP_REMOVE   = 2'd3;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_FULL      = 2'd1;
    localparam t_status ST_EMPTY     = 2'd2;
    localparam t_status ST_NOT_FOUND = 2'd3;

    localparam t_cnt DEPTH_CNT = CNT_W'(DEPTH);
    localparam t_idx LAST_IDX  = IDX_W'(DEPTH - 1);

    // base + off modulo DEPTH, for off below DEPTH
    function automatic t_idx wrap_add(t_idx base, t_idx off);
        logic [IDX_W:0] s;
        s = {1'b0, base} + {1'b0, off};
        if (s >= (IDX_W + 1)'(DEPTH)) begin
            s = s - (IDX_W + 1)'(DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

    function automatic t_idx wrap_inc(t_idx v);
        return (v == LAST_IDX) ? '0 : t_idx'(v + 1'b1);
    endfunction

    function automatic t_idx wrap_dec(t_idx v);
        return (v == '0) ? LAST_IDX : t_idx'(v - 1'b1);
    endfunction

endpackage

/* rtl/ready_queue_with_remove.sv */
// Ready queue with remove: circular pid FIFO held in one RAM, with push, pop,
// contains and remove-by-value. Uses rqr_pkg and rqr_ram.
// Contains and remove scan the entries from the head until a match or the end, and remove
// then shifts each later entry one place toward the head; the single RAM read port walks
// the entries one by one.
// One item at a time: the next beat is taken in the cycle after o_done, which never stalls.
// Reset clears head, tail, count and control; slot contents are not cleared.
module ready_queue_with_remove (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             i_operation,
    input  logic [31:0]            i_pid,
    output logic                   o_done,
    output logic [1:0]             o_status,
    output logic                   o_found,
    output logic [31:0]            o_popped_pid,
    output logic [31:0]            o_head_pid,
    output logic                   o_head_valid,
    output logic [4:0]             o_occupancy,
    output logic                   o_is_empty
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_PUSH     = 4'd1;
    localparam logic [3:0] S_POP      = 4'd2;
    localparam logic [3:0] S_POP_WAIT = 4'd3;
    localparam logic [3:0] S_SCAN     = 4'd4;
    localparam logic [3:0] S_SHIFT_RD = 4'd5;
    localparam logic [3:0] S_SHIFT_WR = 4'd6;
    localparam logic [3:0] S_HEAD_RD  = 4'd7;
    localparam logic [3:0] S_DONE     = 4'd8;

    logic [3:0]              r_state, n_state;
    rqr_pkg::t_op            r_op, n_op;
    rqr_pkg::t_pid           r_key, n_key;
    rqr_pkg::t_idx           r_head, n_head;
    rqr_pkg::t_idx           r_tail, n_tail;
    rqr_pkg::t_cnt           r_count, n_count;
    rqr_pkg::t_cnt           r_i, n_i;
    rqr_pkg::t_cnt           r_cmp_pos, n_cmp_pos;
    logic                    r_pend, n_pend;
    rqr_pkg::t_cnt           r_j, n_j;
    rqr_pkg::t_status        r_status, n_status;
    logic                    r_found, n_found;
    rqr_pkg::t_pid           r_popped, n_popped;

    logic                    w_we;
    rqr_pkg::t_idx           w_waddr;
    rqr_pkg::t_pid           w_wdata;
    logic                    w_re;
    rqr_pkg::t_idx           w_raddr;
    rqr_pkg::t_pid           w_rdata;
    logic [31:0]             w_cnt32;

    rqr_ram #(
        .WIDTH (rqr_pkg::PID_W),
        .DEPTH (rqr_pkg::DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_key     = r_key;
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_i       = r_i;
        n_cmp_pos = r_cmp_pos;
        n_pend    = r_pend;
        n_j       = r_j;
        n_status  = r_status;
        n_found   = r_found;
        n_popped  = r_popped;
        w_we      = 1'b0;
        w_waddr   = r_tail;
        w_wdata   = r_key;
        w_re      = 1'b0;
        w_raddr   = r_head;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op     = i_operation;
                    n_key    = i_pid;
                    n_status = rqr_pkg::ST_OK;
                    n_found  = 1'b0;
                    n_popped = '0;
                    n_i      = '0;
                    n_pend   = 1'b0;
                    unique case (i_operation)
                        rqr_pkg::OP_PUSH: n_state = S_PUSH;
                        rqr_pkg::OP_POP:  n_state = S_POP;
                        default:          n_state = S_SCAN;
                    endcase
                end
            end
            S_PUSH: begin
                if (r_count == rqr_pkg::DEPTH_CNT) begin
                    n_status = rqr_pkg::ST_FULL;
                end else begin
                    w_we    = 1'b1;
                    w_waddr = r_tail;
                    n_tail  = rqr_pkg::wrap_inc(r_tail);
                    n_count = rqr_pkg::t_cnt'(r_count + 1'b1);
                end
                n_state = S_HEAD_RD;
            end
            S_POP: begin
                if (r_count == '0) begin
                    n_status = rqr_pkg::ST_EMPTY;
                    n_state  = S_HEAD_RD;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = r_head;
                    n_state = S_POP_WAIT;
                end
            end
            S_POP_WAIT: begin
                n_popped = w_rdata;
                n_head   = rqr_pkg::wrap_inc(r_head);
                n_count  = rqr_pkg::t_cnt'(r_count - 1'b1);
                n_state  = S_HEAD_RD;
            end
            S_SCAN: begin
                // reads run one entry ahead of the compare
                if (r_pend && (w_rdata == r_key)) begin
                    n_found = 1'b1;
                    n_pend  = 1'b0;
                    if (r_op == rqr_pkg::OP_CONTAINS) begin
                        n_state = S_HEAD_RD;
                    end else begin
                        n_j     = r_cmp_pos;
                        n_state = S_SHIFT_RD;
                    end
                end else if (!r_pend && (r_i >= r_count)) begin
                    n_status = rqr_pkg::ST_NOT_FOUND;
                    n_state  = S_HEAD_RD;
                end else if (r_i < r_count) begin
                    w_re      = 1'b1;
                    w_raddr   = rqr_pkg::wrap_add(r_head, r_i[rqr_pkg::IDX_W-1:0]);
                    n_pend    = 1'b1;
                    n_cmp_pos = r_i;
                    n_i       = rqr_pkg::t_cnt'(r_i + 1'b1);
                end else begin
                    n_pend = 1'b0;
                end
            end
            S_SHIFT_RD: begin
                if (rqr_pkg::t_cnt'(r_j + 1'b1) < r_count) begin
                    w_re    = 1'b1;
                    w_raddr = rqr_pkg::wrap_add(r_head,
                                  rqr_pkg::t_idx'(r_j[rqr_pkg::IDX_W-1:0] + 1'b1));
                    n_state = S_SHIFT_WR;
                end else begin
                    n_tail  = rqr_pkg::wrap_dec(r_tail);
                    n_count = rqr_pkg::t_cnt'(r_count - 1'b1);
                    n_state = S_HEAD_RD;
                end
            end
            S_SHIFT_WR: begin
                // move the later entry one place toward the head
                w_we    = 1'b1;
                w_waddr = rqr_pkg::wrap_add(r_head, r_j[rqr_pkg::IDX_W-1:0]);
                w_wdata = w_rdata;
                n_j     = rqr_pkg::t_cnt'(r_j + 1'b1);
                n_state = S_SHIFT_RD;
            end
            S_HEAD_RD: begin
                w_re    = 1'b1;
                w_raddr = r_head;
                n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_key     <= n_key;
        r_i       <= n_i;
        r_cmp_pos <= n_cmp_pos;
        r_j       <= n_j;
        r_status  <= n_status;
        r_found   <= n_found;
        r_popped  <= n_popped;
    end

    assign w_cnt32 = 32'(r_count);

    assign busy         = (r_state != S_IDLE);
    assign o_done       = (r_state == S_DONE);
    assign o_status     = r_status;
    assign o_found      = r_found;
    assign o_popped_pid = r_popped;
    assign o_head_valid = (r_count != '0);
    assign o_head_pid   = (r_count != '0) ? w_rdata : '0;
    assign o_occupancy  = w_cnt32[rqr_pkg::OCC_W-1:0];
    assign o_is_empty   = (r_count == '0);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= rqr_pkg::DEPTH_CNT)
        else $error("entry count above depth");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == rqr_pkg::ST_FULL)) |-> (r_count == rqr_pkg::DEPTH_CNT))
        else $error("full reported on a queue with room");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_found) |-> (o_status == rqr_pkg::ST_OK))
        else $error("match reported with error status");

endmodule

/* rtl/rqr_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package dependency.
module rqr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sim/ready_queue_with_remove_tb.sv */
// Self-checking testbench for ready_queue_with_remove: directed and random push, pop,
// contains and remove requests, each response checked against a shadow copy of the queue.
// Depends on rqr_pkg and the ready_queue_with_remove RTL.
module ready_queue_with_remove_tb;
    import rqr_pkg::*;

    localparam int TOTAL_ITEMS = 1750;

    typedef struct packed {
        t_status    status;
        logic       found;
        t_pid       popped_pid;
        t_pid       head_pid;
        logic       head_valid;
        logic [4:0] occupancy;
        logic       is_empty;
    } rq_resp_t;

    // Shadow of the ready queue plus the responses still owed by the block.
    class rq_scoreboard;
        t_pid     shadow_slots [DEPTH];
        int       shadow_head;
        int       shadow_tail;
        int       shadow_count;
        rq_resp_t pending_resp [$];
        int       error_count;

        function new();
            shadow_head  = 0;
            shadow_tail  = 0;
            shadow_count = 0;
            error_count  = 0;
            foreach (shadow_slots[k]) shadow_slots[k] = '0;
        endfunction

        function t_pid entry_at(int pos);
            return shadow_slots[(shadow_head + pos) % DEPTH];
        endfunction

        // Position from the head of the first entry equal to key, or -1.
        function int locate_pid(t_pid key);
            for (int k = 0; k < shadow_count; k++) begin
                if (entry_at(k) == key) begin
                    return k;
                end
            end
            return -1;
        endfunction

        function string show_resp(rq_resp_t r);
            return $sformatf("st=%0d found=%0d popped=%08h head=%08h hv=%0d occ=%0d empty=%0d",
                             r.status, r.found, r.popped_pid, r.head_pid, r.head_valid,
                             r.occupancy, r.is_empty);
        endfunction

        function void note_request(t_op op, t_pid key);
            rq_resp_t r;
            int       pos;
            r = '0;
            r.status = ST_OK;
            case (op)
                OP_PUSH: begin
                    if (shadow_count >= DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        shadow_slots[shadow_tail] = key;
                        shadow_tail  = (shadow_tail + 1) % DEPTH;
                        shadow_count = shadow_count + 1;
                    end
                end
                OP_POP: begin
                    if (shadow_count == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        r.popped_pid = shadow_slots[shadow_head];
                        shadow_head  = (shadow_head + 1) % DEPTH;
                        shadow_count = shadow_count - 1;
                    end
                end
                OP_CONTAINS: begin
                    if (locate_pid(key) >= 0) begin
                        r.found = 1'b1;
                    end else begin
                        r.status = ST_NOT_FOUND;
                    end
                end
                default: begin
                    pos = locate_pid(key);
                    if (pos < 0) begin
                        r.status = ST_NOT_FOUND;
                    end else begin
                        r.found = 1'b1;
                        // close the gap: shift later entries one place toward the head
                        for (int j = pos; j + 1 < shadow_count; j++) begin
                            shadow_slots[(shadow_head + j) % DEPTH] =
                                shadow_slots[(shadow_head + j + 1) % DEPTH];
                        end
                        shadow_tail  = (shadow_tail + DEPTH - 1) % DEPTH;
                        shadow_count = shadow_count - 1;
                    end
                end
            endcase
            r.head_valid = (shadow_count != 0);
            r.head_pid   = r.head_valid ? shadow_slots[shadow_head] : '0;
            r.occupancy  = 5'(shadow_count);
            r.is_empty   = (shadow_count == 0);
            pending_resp.push_back(r);
        endfunction

        function void check_response(rq_resp_t got);
            rq_resp_t want;
            string    diffs;
            if (pending_resp.size() == 0) begin
                error_count++;
                if (error_count <= 10) begin
                    $display("ERROR: result with none expected: %s", show_resp(got));
                end
                return;
            end
            want  = pending_resp.pop_front();
            diffs = "";
            if (got.status     !== want.status)     diffs = {diffs, " status"};
            if (got.found      !== want.found)      diffs = {diffs, " found"};
            if (got.popped_pid !== want.popped_pid) diffs = {diffs, " popped_pid"};
            if (got.head_pid   !== want.head_pid)   diffs = {diffs, " head_pid"};
            if (got.head_valid !== want.head_valid) diffs = {diffs, " head_valid"};
            if (got.occupancy  !== want.occupancy)  diffs = {diffs, " occupancy"};
            if (got.is_empty   !== want.is_empty)   diffs = {diffs, " is_empty"};
            if (diffs != "") begin
                error_count++;
                if (error_count <= 10) begin
                    $display("ERROR: mismatch in%s", diffs);
                    $display("  expected %s", show_resp(want));
                    $display("  actual   %s", show_resp(got));
                end
            end
        endfunction
    endclass

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start   = 1'b0;
    t_op        req_op  = OP_PUSH;
    t_pid       req_pid = '0;
    logic       busy;
    logic       o_done;
    logic [1:0] o_status;
    logic       o_found;
    logic [31:0] o_popped_pid;
    logic [31:0] o_head_pid;
    logic       o_head_valid;
    logic [4:0] o_occupancy;
    logic       o_is_empty;

    rq_scoreboard board;
    t_pid         pid_pool [8];
    int           burst_left;
    int           issued;

    always #10 i_clk = ~i_clk;

    ready_queue_with_remove uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_operation  (req_op),
        .i_pid        (req_pid),
        .o_done       (o_done),
        .o_status     (o_status),
        .o_found      (o_found),
        .o_popped_pid (o_popped_pid),
        .o_head_pid   (o_head_pid),
        .o_head_valid (o_head_valid),
        .o_occupancy  (o_occupancy),
        .o_is_empty   (o_is_empty)
    );

    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1) begin
            board.check_response({o_status, o_found, o_popped_pid, o_head_pid,
                                  o_head_valid, o_occupancy, o_is_empty});
        end
    end

    // Present one request and hold it until the block takes the beat.
    // Between bursts drop start for a random gap seven times in ten; inside a burst keep it high.
    task automatic issue_request(t_op op, t_pid key);
        start   <= 1'b1;
        req_op  <= op;
        req_pid <= key;
        do @(posedge i_clk); while (busy !== 1'b0);
        board.note_request(op, key);
        issued++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 20);
            if ($urandom_range(0, 9) >= 3) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 60)) @(posedge i_clk);
            end
        end
    endtask

    function automatic t_pid pick_pid(t_op op);
        int roll;
        roll = $urandom_range(0, 99);
        if ((op == OP_CONTAINS || op == OP_REMOVE) && board.shadow_count > 0 && roll < 50) begin
            return board.entry_at($urandom_range(0, board.shadow_count - 1));
        end
        if (roll < 80) begin
            return pid_pool[$urandom_range(0, 7)];
        end
        return $urandom();
    endfunction

    // Mode 0 leans toward filling, mode 1 toward draining, mode 2 is balanced.
    function automatic t_op pick_op(int mode);
        int roll;
        int push_w;
        int pop_w;
        int look_w;
        roll = $urandom_range(0, 99);
        case (mode)
            0:       begin push_w = 60; pop_w = 15; look_w = 10; end
            1:       begin push_w = 20; pop_w = 45; look_w = 15; end
            default: begin push_w = 35; pop_w = 25; look_w = 20; end
        endcase
        if (roll < push_w) return OP_PUSH;
        if (roll < push_w + pop_w) return OP_POP;
        if (roll < push_w + pop_w + look_w) return OP_CONTAINS;
        return OP_REMOVE;
    endfunction

    initial begin
        int   mode;
        int   chunk;
        int   drain_wait;
        t_op  op;
        board      = new();
        burst_left = $urandom_range(1, 20);
        issued     = 0;
        pid_pool[0] = '0;
        pid_pool[1] = '1;
        for (int k = 2; k < 8; k++) pid_pool[k] = $urandom();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty-queue corners, extremes, duplicates, head and tail removal
        issue_request(OP_POP,      32'h0000_0000);
        issue_request(OP_CONTAINS, 32'h0000_0000);
        issue_request(OP_REMOVE,   32'hFFFF_FFFF);
        issue_request(OP_PUSH,     32'h0000_0000);
        issue_request(OP_PUSH,     32'hFFFF_FFFF);
        issue_request(OP_PUSH,     32'h0000_0000);
        issue_request(OP_PUSH,     32'h5A5A_A5A5);
        issue_request(OP_CONTAINS, 32'hFFFF_FFFF);
        issue_request(OP_CONTAINS, 32'h1234_5678);
        issue_request(OP_REMOVE,   32'h0000_0000);
        issue_request(OP_REMOVE,   32'h5A5A_A5A5);
        issue_request(OP_REMOVE,   32'hDEAD_BEEF);
        issue_request(OP_POP,      32'hFFFF_FFFF);
        issue_request(OP_POP,      32'h0000_0000);
        issue_request(OP_POP,      32'hA5A5_5A5A);

        while (issued < TOTAL_ITEMS) begin
            mode  = $urandom_range(0, 2);
            chunk = $urandom_range(20, 60);
            repeat (chunk) begin
                op = pick_op(mode);
                issue_request(op, pick_pid(op));
            end
        end
        start <= 1'b0;

        drain_wait = 0;
        while (board.pending_resp.size() != 0 && drain_wait < 5000) begin
            @(posedge i_clk);
            drain_wait++;
        end
        repeat (60) @(posedge i_clk);

        if (board.pending_resp.size() != 0) begin
            $display("ERROR: %0d results never arrived", board.pending_resp.size());
            board.error_count += board.pending_resp.size();
        end
        if (board.error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
